>>> hdl/dir_pkg.sv
// ----------------------------------------------------------------------------
// dir_pkg
// Shared types and constants for the decimal integer rounding unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dir_pkg;

	typedef enum logic [1:0] {
		FUNC_FLOOR    = 2'd0,
		FUNC_ROUND    = 2'd1,
		FUNC_TRUNCATE = 2'd2,
		FUNC_NEGATE   = 2'd3
	} dir_func_t;

	localparam int WORD_W  = 32;
	localparam int NUM_W   = 3;
	localparam int SCALE_W = 5;
	localparam int DIGIT_W = 4;

	// ceil(2^39 / 10); exact quotient for any dividend below 2^38
	localparam int          RECIP_W     = 36;
	localparam int          RECIP_SHIFT = 39;
	localparam logic [35:0] RECIP_TEN   = 36'd54975581389;

	// item as it moves down the divider chain
	typedef struct packed {
		dir_func_t                         func;
		logic [NUM_W-1:0][WORD_W-1:0]      words;
		logic [SCALE_W-1:0]                frac;
		logic                              neg;
		logic [SCALE_W-1:0]                ndiv;
		logic [DIGIT_W-1:0]                rem;
		logic [DIGIT_W-1:0]                last;
		logic                              sticky;
	} dir_item_t;

endpackage

`default_nettype wire

>>> hdl/dir_div_step.sv
// ----------------------------------------------------------------------------
// dir_div_step
// One pipeline stage of the divide-by-ten chain: divides one 32-bit word,
// with the remainder carried in from the word above, by ten, while the item still has digits to divide.
// ----------------------------------------------------------------------------
`default_nettype none

module dir_div_step #(
	parameter int DIGIT = 0,
	parameter int WORD  = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              up_valid,
	input  wire dir_pkg::dir_item_t up_item,
	output logic                   dn_valid,
	output dir_pkg::dir_item_t     dn_item
);

	localparam int PROD_W = 2 * dir_pkg::RECIP_W;

	logic                              active;
	logic [dir_pkg::DIGIT_W-1:0]       rem_in;
	logic [dir_pkg::RECIP_W-1:0]       cur;
	logic [PROD_W-1:0]                 prod;
	logic [dir_pkg::WORD_W-1:0]        quot;
	logic [dir_pkg::DIGIT_W-1:0]       ten_q_lo;
	logic [dir_pkg::DIGIT_W-1:0]       rem_out;
	dir_pkg::dir_item_t                nxt;

	assign active = up_item.ndiv > dir_pkg::SCALE_W'(DIGIT);
	// the top word opens each digit with a zero remainder
	assign rem_in = (WORD == dir_pkg::NUM_W - 1) ? '0 : up_item.rem;
	assign cur    = {rem_in, up_item.words[WORD]};
	assign prod   = {{(PROD_W-dir_pkg::RECIP_W){1'b0}}, cur}
	              * {{(PROD_W-dir_pkg::RECIP_W){1'b0}}, dir_pkg::RECIP_TEN};
	assign quot   = prod[dir_pkg::RECIP_SHIFT +: dir_pkg::WORD_W];

	// remainder from the low bits only: cur - 10*q, which is below ten
	assign ten_q_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
	assign rem_out  = cur[dir_pkg::DIGIT_W-1:0] - ten_q_lo;

	always_comb begin
		nxt = up_item;
		if (active) begin
			nxt.words[WORD] = quot;
			nxt.rem         = rem_out;
			if (WORD == 0) begin
				nxt.last   = rem_out;
				nxt.sticky = up_item.sticky | (rem_out != '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (en) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_item <= nxt;
		end
	end

endmodule

`default_nettype wire

>>> hdl/decimal_integer_rounding_unit.sv
// Throughput: one item per cycle while the output is not stalled; each decimal
// digit takes three stages, one per 32-bit word, each a 36x36 reciprocal
// multiply, then one increment stage.
// A stall at a valid output freezes the whole pipeline and holds the input off.
// Reset clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// decimal_integer_rounding_unit
// Floor, round, truncate and negate of a 96-bit decimal with scale.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_integer_rounding_unit #(
	parameter int MAX_SCALE = 28
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] word_low,
	input  wire logic [31:0] word_mid,
	input  wire logic [31:0] word_high,
	input  wire logic [4:0]  frac_digits,
	input  wire logic        negative,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      out_word_low,
	output logic [31:0]      out_word_mid,
	output logic [31:0]      out_word_high,
	output logic [4:0]       out_frac_digits,
	output logic             out_negative
);

	localparam int          STAGES = 3 * MAX_SCALE;
	localparam logic [4:0]  MAX_N  = 5'(MAX_SCALE);

	logic                 en;
	logic                 chain_valid [0:STAGES];
	dir_pkg::dir_item_t   chain       [0:STAGES];
	dir_pkg::dir_func_t   in_func;
	logic [4:0]           in_ndiv;

	dir_pkg::dir_item_t   fin;
	logic                 do_inc;
	logic [95:0]          mag;
	logic [95:0]          mag_inc;

	logic [95:0]          res_q;
	logic [4:0]           frac_q;
	logic                 neg_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign in_func = dir_pkg::dir_func_t'(func);
	always_comb begin
		if (in_func == dir_pkg::FUNC_NEGATE) begin
			in_ndiv = '0;
		end else if (frac_digits > MAX_N) begin
			in_ndiv = MAX_N;
		end else begin
			in_ndiv = frac_digits;
		end
	end

	always_comb begin
		chain[0].func   = in_func;
		chain[0].words  = {word_high, word_mid, word_low};
		chain[0].frac   = frac_digits;
		chain[0].neg    = negative;
		chain[0].ndiv   = in_ndiv;
		chain[0].rem    = '0;
		chain[0].last   = '0;
		chain[0].sticky = 1'b0;
	end
	assign chain_valid[0] = in_valid;

	for (genvar s = 0; s < STAGES; s++) begin : g_step
		localparam int DIGIT = s / 3;
		localparam int WORD  = 2 - (s % 3);
		dir_div_step #(
			.DIGIT (DIGIT),
			.WORD  (WORD)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (chain_valid[s]),
			.up_item  (chain[s]),
			.dn_valid (chain_valid[s+1]),
			.dn_item  (chain[s+1])
		);
	end

	// final increment for floor of a negative inexact value and for round
	assign fin = chain[STAGES];
	always_comb begin
		case (fin.func)
			dir_pkg::FUNC_FLOOR: do_inc = fin.neg && fin.sticky;
			dir_pkg::FUNC_ROUND: do_inc = fin.last >= 4'd5;
			default:             do_inc = 1'b0;
		endcase
	end
	assign mag     = fin.words;
	assign mag_inc = mag + 96'(do_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= chain_valid[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= mag_inc;
			if (fin.func == dir_pkg::FUNC_NEGATE) begin
				frac_q <= fin.frac;
				neg_q  <= !fin.neg;
			end else begin
				frac_q <= '0;
				neg_q  <= fin.neg;
			end
		end
	end

	assign out_word_low    = res_q[31:0];
	assign out_word_mid    = res_q[63:32];
	assign out_word_high   = res_q[95:64];
	assign out_frac_digits = frac_q;
	assign out_negative    = neg_q;

endmodule

`default_nettype wire
